// File: hw/rtl/time_window_rule_matcher_defines.svh
// Assertion macros for the rule matcher checker.
// Each one samples on clk and is off while rst_n is low.
`ifndef TIME_WINDOW_RULE_MATCHER_DEFINES_SVH
`define TIME_WINDOW_RULE_MATCHER_DEFINES_SVH

// Same-cycle implication.
`define TWRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the next cycle.
`define TWRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication.
`define TWRM_ASSERT_DLY2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/twrm_pkg.sv
package twrm_pkg;

  localparam int NOW_W    = 63;
  localparam int TOD_W    = 17;
  localparam int MIN_W    = 11;
  localparam int OFFSET_W = 17;
  localparam int HITS_W   = 32;
  localparam int IDX_W    = 4;

  localparam logic [TOD_W-1:0] SECONDS_PER_DAY = 17'd86400;
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int MINUTES_PER_HOUR   = 60;

  // floor(x / 60) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 161319
  localparam int DIV_SHIFT = 23;
  localparam int RECIP_W   = 18;
  localparam int DIV_RECIP = (2**DIV_SHIFT + SECONDS_PER_MINUTE - 1) / SECONDS_PER_MINUTE;

  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd28800;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] rule_index;
    logic [4:0]       open_hour;
    logic [5:0]       start_minute;
    logic [4:0]       close_hour;
    logic [5:0]       end_minute;
    logic             drop_action;
    logic             rule_enable;
    logic [NOW_W-1:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic              verdict;
    logic              time_hit;
    logic [IDX_W-1:0]  hit_index;
    logic [HITS_W-1:0] hit_count;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic [MIN_W-1:0] minute;
  } tod_res_t;

endpackage

// File: hw/rtl/twrm_tod.sv
module twrm_tod (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [twrm_pkg::NOW_W-1:0]            now_seconds,
  input  logic signed [twrm_pkg::OFFSET_W-1:0]  offset,
  output twrm_pkg::tod_res_t                    res
);
  import twrm_pkg::*;

  localparam int CHUNK   = 8;
  localparam int CHUNKS  = 8;
  localparam int SHIFT_W = CHUNK * CHUNKS;
  localparam int CNT_W   = $clog2(CHUNKS);
  localparam int PROD_W  = TOD_W + RECIP_W;
  localparam int SUM_W   = TOD_W + 2;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_FOLD = 2'd1;
  localparam logic [1:0] T_OFFS = 2'd2;
  localparam logic [1:0] T_MUL  = 2'd3;

  localparam logic signed [SUM_W-1:0] DAY_S = SUM_W'(SECONDS_PER_DAY);

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [TOD_W-1:0]   rem_r, rem_nxt;
  logic [TOD_W-1:0]   tod_r, tod_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic               done_r, done_nxt;

  logic [TOD_W-1:0]       rem_fold;
  logic [TOD_W:0]         fold_t;
  logic signed [SUM_W-1:0] sum_s;
  logic signed [SUM_W-1:0] adj_s;

  // Residue mod 86400, eight bits MSB first per cycle; each bit is one
  // double-and-reduce, and since rem < 86400 one subtract is enough.
  always_comb begin
    rem_fold = rem_r;
    fold_t   = '0;
    for (int i = 0; i < CHUNK; i++) begin
      fold_t = {rem_fold, shift_r[SHIFT_W-1-i]};
      if (fold_t >= {1'b0, SECONDS_PER_DAY}) begin
        fold_t = fold_t - {1'b0, SECONDS_PER_DAY};
      end
      rem_fold = fold_t[TOD_W-1:0];
    end
  end

  // offset is in [-65536, 65535], so one correction either way
  always_comb begin
    sum_s = $signed({2'b00, rem_r}) + $signed({{2{offset[OFFSET_W-1]}}, offset});
    if (sum_s < 0) begin
      adj_s = sum_s + DAY_S;
    end else if (sum_s >= DAY_S) begin
      adj_s = sum_s - DAY_S;
    end else begin
      adj_s = sum_s;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    tod_nxt   = tod_r;
    done_nxt  = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (start) begin
          shift_nxt = SHIFT_W'(now_seconds);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = T_FOLD;
        end
      end
      T_FOLD: begin
        rem_nxt   = rem_fold;
        shift_nxt = shift_r << CHUNK;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CHUNKS - 1)) begin
          state_nxt = T_OFFS;
        end
      end
      T_OFFS: begin
        tod_nxt   = adj_s[TOD_W-1:0];
        state_nxt = T_MUL;
      end
      T_MUL: begin
        done_nxt  = 1'b1;
        state_nxt = T_IDLE;
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    tod_r   <= tod_nxt;
    if (state_r == T_MUL) begin
      prod_r <= PROD_W'(tod_r) * PROD_W'(DIV_RECIP);
    end
  end

  assign res.done   = done_r;
  assign res.minute = prod_r[DIV_SHIFT +: MIN_W];

endmodule

// File: hw/rtl/time_window_rule_matcher.sv
// Write item: result registered from ST_WRITE; next item may start as it shows.
// Packet item: twrm_tod turns now_seconds into a local minute, then the rule
// memory is scanned one slot per cycle until the first matching slot or the last.
// One item at a time: busy stays high until the result shows, and the strobe is
// never held off by the receiver. Reset clears every rule's valid bit and sets
// the UTC offset to 28800 s; rule memory contents are left as they are.
module time_window_rule_matcher #(
  parameter int RULE_SLOTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  twrm_pkg::in_item_t                    in_item,
  output logic                                  out_strobe,
  output twrm_pkg::out_item_t                   out_item,
  input  logic                                  cfg_we,
  input  logic signed [twrm_pkg::OFFSET_W-1:0]  cfg_wdata
);
  import twrm_pkg::*;

  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_TOD   = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  // One rule slot as held in memory (window bounds in minutes of day).
  typedef struct packed {
    logic [MIN_W-1:0]  win_start;
    logic [MIN_W-1:0]  win_end;
    logic              drop;
    logic [HITS_W-1:0] hits;
  } rule_entry_t;

  function automatic logic in_window(input logic [MIN_W-1:0] now_min,
                                     input logic [MIN_W-1:0] lo,
                                     input logic [MIN_W-1:0] hi);
    logic res;
    if (lo > hi) begin
      // window wraps past midnight
      res = (now_min >= lo) || (now_min <= hi);
    end else begin
      res = (now_min >= lo) && (now_min <= hi);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- state
  logic [1:0]                   state_r, state_nxt;
  logic signed [OFFSET_W-1:0]   cfg_offset_r;
  logic [RULE_SLOTS-1:0]        slot_valid_r, slot_valid_nxt;
  logic [MIN_W-1:0]             minute_r, minute_nxt;
  logic [CNT_W-1:0]             issue_cnt_r, issue_cnt_nxt;
  logic                         rd_live_r, rd_live_nxt;
  logic [SLOT_W-1:0]            rd_slot_r, rd_slot_nxt;
  logic                         rd_vld_r;
  rule_entry_t                  rd_data_r;
  logic                         out_strobe_r, out_strobe_nxt;
  out_item_t                    out_item_r, out_item_nxt;

  // latched write item, window bounds already folded to minutes
  logic [IDX_W-1:0]             wr_index_r;
  logic [MIN_W-1:0]             wr_start_r;
  logic [MIN_W-1:0]             wr_end_r;
  logic                         wr_drop_r;
  logic                         wr_en_r;

  // rule memory: one write port, one registered read port
  rule_entry_t                  rule_mem [RULE_SLOTS];
  logic                         mem_we;
  logic [SLOT_W-1:0]            mem_waddr;
  rule_entry_t                  mem_wdata;
  logic                         mem_re;
  logic [SLOT_W-1:0]            mem_raddr;

  logic                         accept;
  logic                         wr_ok;
  logic [SLOT_W-1:0]            wr_addr;
  logic [MIN_W-1:0]             in_start_min;
  logic [MIN_W-1:0]             in_end_min;
  logic                         eval_hit;
  logic                         eval_last;
  logic [HITS_W-1:0]            new_hits;
  tod_res_t                     tod_res;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign in_start_min = MIN_W'(in_item.open_hour) * MIN_W'(MINUTES_PER_HOUR)
                      + MIN_W'(in_item.start_minute);
  assign in_end_min   = MIN_W'(in_item.close_hour) * MIN_W'(MINUTES_PER_HOUR)
                      + MIN_W'(in_item.end_minute);

  // Slots beyond the table are silently dropped on write.
  assign wr_ok   = 32'(wr_index_r) < RULE_SLOTS;
  assign wr_addr = SLOT_W'(wr_index_r);

  // -------------------------------------------------------- time of day
  // Runs in parallel with nothing else: started straight off the accept edge.
  twrm_tod u_tod (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept && (in_item.op == OP_PACKET)),
    .now_seconds (in_item.now_seconds),
    .offset      (cfg_offset_r),
    .res         (tod_res)
  );

  // --------------------------------------------------------------- scan
  // Reads are issued one slot per cycle; the slot read last cycle is judged
  // now. The first hit stops the scan and writes the bumped counter back in
  // the same cycle; any read still in flight is discarded. No write can
  // overlap a read of the same entry since items never overlap.
  assign eval_hit  = rd_live_r && rd_vld_r &&
                     in_window(minute_r, rd_data_r.win_start, rd_data_r.win_end);
  assign eval_last = rd_live_r && (rd_slot_r == SLOT_W'(RULE_SLOTS - 1));
  assign new_hits  = rd_data_r.hits + HITS_W'(1);

  always_comb begin
    state_nxt      = state_r;
    slot_valid_nxt = slot_valid_r;
    minute_nxt     = minute_r;
    issue_cnt_nxt  = issue_cnt_r;
    rd_live_nxt    = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = issue_cnt_r[SLOT_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_item.op == OP_WRITE) ? ST_WRITE : ST_TOD;
        end
      end

      ST_WRITE: begin
        // a rewrite always restarts the slot's hit count
        if (wr_ok) begin
          mem_we                  = 1'b1;
          mem_wdata.win_start     = wr_start_r;
          mem_wdata.win_end       = wr_end_r;
          mem_wdata.drop          = wr_drop_r;
          mem_wdata.hits          = '0;
          slot_valid_nxt[wr_addr] = wr_en_r;
        end
        out_strobe_nxt = 1'b1;
        out_item_nxt   = '0;
        state_nxt      = ST_IDLE;
      end

      ST_TOD: begin
        if (tod_res.done) begin
          minute_nxt    = tod_res.minute;
          issue_cnt_nxt = '0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (issue_cnt_r != CNT_W'(RULE_SLOTS)) begin
          mem_re        = 1'b1;
          rd_live_nxt   = 1'b1;
          rd_slot_nxt   = mem_raddr;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
        if (eval_hit) begin
          mem_we                 = 1'b1;
          mem_waddr              = rd_slot_r;
          mem_wdata              = rd_data_r;
          mem_wdata.hits         = new_hits;
          out_strobe_nxt         = 1'b1;
          out_item_nxt.verdict   = rd_data_r.drop;
          out_item_nxt.time_hit  = 1'b1;
          out_item_nxt.hit_index = IDX_W'(rd_slot_r);
          out_item_nxt.hit_count = new_hits;
          rd_live_nxt            = 1'b0;
          state_nxt              = ST_IDLE;
        end else if (eval_last) begin
          // no rule matched: accept, unmarked
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '0;
          rd_live_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_offset_r <= OFFSET_RESET;
      slot_valid_r <= '0;
      rd_live_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      rd_live_r    <= rd_live_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        cfg_offset_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    minute_r    <= minute_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    rd_slot_r   <= rd_slot_nxt;
    out_item_r  <= out_item_nxt;
    if (accept) begin
      wr_index_r <= in_item.rule_index;
      wr_start_r <= in_start_min;
      wr_end_r   <= in_end_min;
      wr_drop_r  <= in_item.drop_action;
      wr_en_r    <= in_item.rule_enable;
    end
  end

  // rule memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rule_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= rule_mem[mem_raddr];
      rd_vld_r  <= slot_valid_r[mem_raddr];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: hw/rtl/twrm_checker.sv
`include "time_window_rule_matcher_defines.svh"

module twrm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input twrm_pkg::in_item_t   in_item,
  input logic                 out_strobe,
  input twrm_pkg::out_item_t  out_item
);
  import twrm_pkg::*;

  // taking an item always makes the block busy
  `TWRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but busy stayed low")

  // exactly one result per item, shown as busy drops
  `TWRM_ASSERT_NOW(a_strobe_on_fall, 1'b1, out_strobe == (!busy && $past(busy)), "result strobe not aligned with end of item")

  // a rule write reports with all fields clear
  `TWRM_ASSERT_DLY2(a_write_result, start && !busy && in_item.op == OP_WRITE, out_strobe && out_item == '0, "write item result missing or not clear")

  // no match means accept with no slot and no count
  `TWRM_ASSERT_NOW(a_miss_clean, out_strobe && !out_item.time_hit, out_item.verdict == 1'b0 && out_item.hit_index == '0 && out_item.hit_count == '0, "unmatched packet carries hit data")

endmodule

bind time_window_rule_matcher twrm_checker u_twrm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// File: tb/sv/time_window_rule_matcher_tb.sv
module time_window_rule_matcher_tb;
  import twrm_pkg::*;

  localparam int SLOTS       = 16;
  localparam int DAY_SECONDS = 86400;
  localparam int DAY_MINUTES = 1440;
  localparam int IN_W        = $bits(in_item_t);
  // Longest quiet spell: a full scan plus the widest sender gap, phase turnarounds
  // and the settle at the end, with plenty of margin.
  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic signed [OFFSET_W-1:0] cfg_wdata = '0;

  time_window_rule_matcher #(.RULE_SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predicted rule table: our own copy of the slots, counters and offset.
  // ---------------------------------------------------------------------------
  logic                       slot_on   [SLOTS];
  logic [MIN_W-1:0]           rule_lo   [SLOTS];
  logic [MIN_W-1:0]           rule_hi   [SLOTS];
  logic                       rule_drop [SLOTS];
  logic [HITS_W-1:0]          rule_hits [SLOTS];
  logic signed [OFFSET_W-1:0] tz_offset = OFFSET_RESET;

  // Stimulus-side view of the windows, so packets can be aimed at edges.
  int plan_lo [SLOTS];
  int plan_hi [SLOTS];

  in_item_t  pending_items[$];     // items waiting for the driver
  out_item_t expected_verdicts[$]; // results owed by the block, oldest first
  int        mismatches = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i] = 1'b0;
      plan_lo[i] = 0;
      plan_hi[i] = 0;
    end
  end

  // Applies one accepted item to the predicted table and returns its result.
  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t        res;
    longint unsigned  now_mod;
    int               off, tod, minute, lo, hi;
    bit               found;
    res = '0;
    if (it.op == OP_WRITE) begin
      rule_lo[it.rule_index]   = MIN_W'(int'(it.open_hour) * MINUTES_PER_HOUR
                                        + int'(it.start_minute));
      rule_hi[it.rule_index]   = MIN_W'(int'(it.close_hour) * MINUTES_PER_HOUR
                                        + int'(it.end_minute));
      rule_drop[it.rule_index] = it.drop_action;
      slot_on[it.rule_index]   = it.rule_enable;
      rule_hits[it.rule_index] = '0;
      return res;
    end
    // local time of day: offset shifted by two days so the sum stays positive
    now_mod = 64'(it.now_seconds) % 64'(DAY_SECONDS);
    off     = int'(tz_offset);
    off     = (off + 2 * DAY_SECONDS) % DAY_SECONDS;
    tod     = (int'(now_mod) + off) % DAY_SECONDS;
    minute  = tod / SECONDS_PER_MINUTE;
    found   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      lo = int'(rule_lo[i]);
      hi = int'(rule_hi[i]);
      if (!found && slot_on[i] &&
          ((lo > hi) ? (minute >= lo || minute <= hi) : (minute >= lo && minute <= hi))) begin
        found         = 1'b1;
        rule_hits[i]  = rule_hits[i] + 1'b1;
        res.verdict   = rule_drop[i];
        res.time_hit  = 1'b1;
        res.hit_index = i[IDX_W-1:0];
        res.hit_count = rule_hits[i];
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  // UTC seconds that land in the given local minute under offset off;
  // the day count is mostly huge so the upper bits of now_seconds toggle.
  function automatic logic [NOW_W-1:0] now_at_minute(int minute_of_day,
                                                     logic signed [OFFSET_W-1:0] off);
    longint unsigned day;
    int              local_s, utc_s;
    local_s = minute_of_day * SECONDS_PER_MINUTE + $urandom_range(0, 59);
    utc_s   = ((local_s - int'(off)) % DAY_SECONDS + DAY_SECONDS) % DAY_SECONDS;
    day     = {$urandom, $urandom} & 64'h3FFF_FFFF_FFFF;
    if ($urandom_range(0, 3) == 0) day = 64'($urandom_range(0, 3));
    return NOW_W'(day * DAY_SECONDS + utc_s);
  endfunction

  task automatic queue_rule_write(int idx, int sh, int sm, int eh, int em, bit drop, bit en);
    in_item_t it;
    it              = IN_W'({$urandom, $urandom, $urandom});  // filler in unused fields
    it.op           = OP_WRITE;
    it.rule_index   = IDX_W'(idx);
    it.open_hour    = 5'(sh);
    it.start_minute = 6'(sm);
    it.close_hour   = 5'(eh);
    it.end_minute   = 6'(em);
    it.drop_action  = drop;
    it.rule_enable  = en;
    plan_lo[idx]    = sh * MINUTES_PER_HOUR + sm;
    plan_hi[idx]    = eh * MINUTES_PER_HOUR + em;
    pending_items.push_back(it);
  endtask

  task automatic queue_packet(logic [NOW_W-1:0] now);
    in_item_t it;
    it             = IN_W'({$urandom, $urandom, $urandom});
    it.op          = OP_PACKET;
    it.now_seconds = now;
    pending_items.push_back(it);
  endtask

  // Random mix: about a third rule writes, the bulk packets aimed at window
  // edges of some slot, and a tail of packets with raw 63-bit times.
  task automatic queue_random_items(int count);
    int r, s, m;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        if (r < 5)  // hours and minutes beyond the clock
          queue_rule_write($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 63),
                           $urandom_range(0, 31), $urandom_range(0, 63),
                           1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
        else
          queue_rule_write($urandom_range(0, 15), $urandom_range(0, 23), $urandom_range(0, 59),
                           $urandom_range(0, 23), $urandom_range(0, 59),
                           1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
      end else if (r < 88) begin
        s = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 4))
          0: m = plan_lo[s];
          1: m = plan_hi[s];
          2: m = plan_lo[s] - 1;
          3: m = plan_hi[s] + 1;
          default: m = $urandom_range(0, DAY_MINUTES - 1);
        endcase
        m = (m % DAY_MINUTES + DAY_MINUTES) % DAY_MINUTES;
        queue_packet(now_at_minute(m, tz_offset));
      end else begin
        queue_packet(NOW_W'({$urandom, $urandom}));
      end
    end
  endtask

  // Offset register: written only with the block idle.
  task automatic load_utc_offset(logic signed [OFFSET_W-1:0] v);
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tz_offset  = v;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || start || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back items separated by random gaps.
  // ---------------------------------------------------------------------------
  int gap_left   = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_verdicts.push_back(predict_verdict(in_item));
      // slot free: nothing on offer, or the offered item went in at this edge
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          start   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe retires the oldest expectation.
  // ---------------------------------------------------------------------------
  out_item_t verdict_due;

  function automatic void check_field(string name, logic [HITS_W-1:0] want,
                                      logic [HITS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, out_item);
        mismatches++;
      end else begin
        verdict_due = expected_verdicts.pop_front();
        check_field("verdict",   HITS_W'(verdict_due.verdict),   HITS_W'(out_item.verdict));
        check_field("time_hit",  HITS_W'(verdict_due.time_hit),  HITS_W'(out_item.time_hit));
        check_field("hit_index", HITS_W'(verdict_due.hit_index), HITS_W'(out_item.hit_index));
        check_field("hit_count", verdict_due.hit_count, out_item.hit_count);
      end
    end
  end

  // Watchdog: a run of cycles with no item in, no result out and no write.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("time_window_rule_matcher: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed items and a random phase at the reset offset, then random
  // phases under a range of offsets including both signed extremes of the register.
  // ---------------------------------------------------------------------------
  logic signed [OFFSET_W-1:0] offset_plan[6];

  initial begin
    offset_plan = '{17'sd50400, -17'sd50400, 17'sd65535, -17'sd65536, 17'sd0,
                    OFFSET_W'($urandom)};

    // empty table: no match
    queue_packet('0);
    // midnight-only rule in slot 0, wrapping 23:59..00:00 rule in the last slot
    queue_rule_write(0, 0, 0, 0, 0, 1'b0, 1'b1);
    queue_rule_write(15, 23, 59, 0, 0, 1'b1, 1'b1);
    queue_packet(now_at_minute(0, tz_offset));
    queue_packet(now_at_minute(DAY_MINUTES - 1, tz_offset));
    queue_packet(now_at_minute(1, tz_offset));
    // slot 0 removed: midnight now falls through to the wrapping rule
    queue_rule_write(0, 0, 0, 0, 0, 1'b0, 1'b0);
    queue_packet(now_at_minute(0, tz_offset));
    // hour and minute past the clock: both windows open beyond minute 1439
    queue_rule_write(7, 31, 63, 31, 63, 1'b1, 1'b1);
    queue_rule_write(8, 31, 63, 0, 10, 1'b0, 1'b1);
    queue_packet(now_at_minute(5, tz_offset));
    queue_packet({NOW_W{1'b1}});
    // whole-day rule, then a rewrite that restarts its counter
    queue_rule_write(3, 0, 0, 23, 59, 1'b1, 1'b1);
    queue_packet(now_at_minute(720, tz_offset));
    queue_rule_write(3, 0, 0, 23, 59, 1'b1, 1'b1);
    queue_packet(now_at_minute(720, tz_offset));
    queue_packet({NOW_W{1'b1}});
    queue_rule_write(15, 31, 63, 31, 63, 1'b1, 1'b1);
    queue_packet(now_at_minute(DAY_MINUTES - 1, tz_offset));
    queue_rule_write(3, 0, 0, 23, 59, 1'b1, 1'b0);
    queue_packet(now_at_minute(720, tz_offset));
    queue_random_items(170);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (offset_plan[p]) begin
      wait_idle();
      load_utc_offset(offset_plan[p]);
      queue_random_items(170);
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("time_window_rule_matcher: match");
    else
      $display("time_window_rule_matcher: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/twrm_pkg.sv
hw/rtl/twrm_tod.sv
hw/rtl/time_window_rule_matcher.sv
hw/rtl/twrm_checker.sv
tb/sv/time_window_rule_matcher_tb.sv
